FILE: src/triangle_vertex_transform_macros.svh
// Assertion macros shared by the triangle vertex transform RTL.
`ifndef TRIANGLE_VERTEX_TRANSFORM_MACROS_SVH
`define TRIANGLE_VERTEX_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define TVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tvt assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define TVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tvt assertion failed");

`endif

FILE: src/tvt_pkg.sv
// Shared types and constants of the triangle vertex transform.
package tvt_pkg;

    localparam int COORD_W  = 16;
    localparam int ROW_W    = 64;
    localparam int SIZE_W   = 13;
    localparam int PROD_W   = 32;
    localparam int CLIP_W   = 34;
    localparam int NUM_W    = 51;
    localparam int DEN_W    = CLIP_W;
    localparam int QUO_W    = 18;
    localparam int XY_W     = 18;
    localparam int Z_W      = 16;
    localparam int MAX_VERTS = 3;
    localparam int DEF_VERTS = 3;

    // Lane front end: input, products, clip sums, numerators.
    localparam int LANE_STG = 4;
    // Divider: prep, overflow check, one stage per quotient bit, saturation.
    localparam int DIV_STG  = QUO_W + 3;
    // Lane, divider and the merged output register.
    localparam int NSTG     = LANE_STG + DIV_STG + 1;

    localparam logic [ROW_W-1:0]  ROW0_RST   = 64'h0000_0000_0000_0800;
    localparam logic [ROW_W-1:0]  ROW1_RST   = 64'h0000_0000_0800_0000;
    localparam logic [ROW_W-1:0]  ROW2_RST   = 64'h0000_0800_0000_0000;
    localparam logic [ROW_W-1:0]  ROW3_RST   = 64'h0800_0000_0000_0000;
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } cfg_idx_t;

    typedef logic [NSTG-1:0] stage_en_t;
    typedef logic [3:0][ROW_W-1:0] matrix_t;

    typedef struct packed {
        logic neg;
        logic npos;
        logic nneg;
        logic dz;
        logic ovf;
    } div_flags_t;

endpackage

FILE: src/tvt_div.sv
// Pipelined rounding divider with saturation, one quotient bit per stage.
module tvt_div #(
    parameter int OUT_W = tvt_pkg::XY_W
) (
    input  logic                              aclk,
    input  logic [tvt_pkg::DIV_STG-1:0]       en,
    input  logic signed [tvt_pkg::NUM_W-1:0]  num,
    input  logic signed [tvt_pkg::DEN_W-1:0]  den,
    output logic signed [OUT_W-1:0]           q,
    output logic                              dz
);
    import tvt_pkg::*;

    localparam int REM_W = NUM_W + 1;
    localparam int LAST  = QUO_W + 1;
    localparam logic [QUO_W-1:0] HI_Q = QUO_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [QUO_W-1:0] LO_Q = QUO_W'(1 << (OUT_W - 1));
    localparam logic signed [OUT_W-1:0] HI_V = OUT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [OUT_W-1:0] LO_V = OUT_W'(1 << (OUT_W - 1));

    logic [REM_W-1:0] rem_reg [0:LAST];
    logic [DEN_W-1:0] d_reg   [0:LAST];
    logic [QUO_W-1:0] q_reg   [0:LAST];
    div_flags_t       f_reg   [0:LAST];

    logic [NUM_W-1:0] an;
    logic [DEN_W-1:0] ad;
    logic signed [OUT_W-1:0] q_next;

    assign an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign ad = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // Rounding to nearest is folded in by adding half the divisor up front.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]    <= REM_W'(an) + REM_W'(ad >> 1);
            d_reg[0]      <= ad;
            q_reg[0]      <= '0;
            f_reg[0].neg  <= num[NUM_W-1] ^ den[DEN_W-1];
            f_reg[0].npos <= !num[NUM_W-1] && (num != '0);
            f_reg[0].nneg <= num[NUM_W-1];
            f_reg[0].dz   <= (den == '0);
            f_reg[0].ovf  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            rem_reg[1]    <= rem_reg[0];
            d_reg[1]      <= d_reg[0];
            q_reg[1]      <= '0;
            f_reg[1].neg  <= f_reg[0].neg;
            f_reg[1].npos <= f_reg[0].npos;
            f_reg[1].nneg <= f_reg[0].nneg;
            f_reg[1].dz   <= f_reg[0].dz;
            f_reg[1].ovf  <= rem_reg[0] >= {d_reg[0], QUO_W'(0)};
        end
    end

    for (genvar k = 2; k <= LAST; k++) begin : g_iter
        localparam int BIT = LAST - k;
        logic [REM_W-1:0] sub;
        logic             ge;
        assign sub = REM_W'(d_reg[k-1]) << BIT;
        assign ge  = rem_reg[k-1] >= sub;
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= ge ? rem_reg[k-1] - sub : rem_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (QUO_W'(ge) << BIT);
                f_reg[k]   <= f_reg[k-1];
            end
        end
    end

    always_comb begin
        if (f_reg[LAST].dz) begin
            q_next = f_reg[LAST].npos ? HI_V : (f_reg[LAST].nneg ? LO_V : '0);
        end else if (f_reg[LAST].ovf) begin
            q_next = f_reg[LAST].neg ? LO_V : HI_V;
        end else if (f_reg[LAST].neg) begin
            q_next = (q_reg[LAST] > LO_Q) ? LO_V : -OUT_W'(q_reg[LAST]);
        end else begin
            q_next = (q_reg[LAST] > HI_Q) ? HI_V : OUT_W'(q_reg[LAST]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[DIV_STG-1]) begin
            q  <= q_next;
            dz <= f_reg[LAST].dz;
        end
    end

endmodule

FILE: src/tvt_lane.sv
// One vertex lane: matrix product, viewport numerators and three dividers.
module tvt_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tvt_pkg::stage_en_t                  en,
    input  tvt_pkg::matrix_t                    mvp,
    input  logic [tvt_pkg::SIZE_W-1:0]          width,
    input  logic [tvt_pkg::SIZE_W-1:0]          height,
    input  logic signed [tvt_pkg::COORD_W-1:0]  vx,
    input  logic signed [tvt_pkg::COORD_W-1:0]  vy,
    input  logic signed [tvt_pkg::COORD_W-1:0]  vz,
    output logic signed [tvt_pkg::XY_W-1:0]     sx,
    output logic signed [tvt_pkg::XY_W-1:0]     sy,
    output logic signed [tvt_pkg::Z_W-1:0]      sz,
    output logic                                wz
);
    import tvt_pkg::*;

    logic signed [COORD_W-1:0] vec_reg [0:2];
    logic signed [PROD_W-1:0]  prod_reg [0:3][0:3];
    logic signed [CLIP_W-1:0]  clip_reg [0:3];
    logic signed [NUM_W-1:0]   numx_reg, numy_reg, numz_reg;
    logic signed [DEN_W-1:0]   den_reg;

    logic signed [CLIP_W:0]    sumx, sumy;
    logic signed [CLIP_W+SIZE_W+1:0] px, py;
    logic                      dzy, dzz;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            vec_reg[0] <= vx;
            vec_reg[1] <= vy;
            vec_reg[2] <= vz;
        end
    end

    // The fourth column multiplies the implied w of one, 4096 in Q4.12.
    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            logic signed [COORD_W-1:0] e;
            assign e = mvp[r][COORD_W*c +: COORD_W];
            if (c == 3) begin : g_w
                always_ff @(posedge aclk) begin
                    if (en[1]) begin
                        prod_reg[r][c] <= {{4{e[COORD_W-1]}}, e, 12'b0};
                    end
                end
            end else begin : g_v
                always_ff @(posedge aclk) begin
                    if (en[1]) begin
                        prod_reg[r][c] <= e * vec_reg[c];
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en[2]) begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2]) + CLIP_W'(prod_reg[r][3]);
            end
        end
    end

    assign sumx = (CLIP_W+1)'(clip_reg[0]) + (CLIP_W+1)'(clip_reg[3]);
    assign sumy = (CLIP_W+1)'(clip_reg[3]) - (CLIP_W+1)'(clip_reg[1]);
    assign px   = sumx * $signed({1'b0, width});
    assign py   = sumy * $signed({1'b0, height});

    // Screen x and y carry four fraction bits, hence the factor of eight.
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            numx_reg <= {px[NUM_W-4:0], 3'b0};
            numy_reg <= {py[NUM_W-4:0], 3'b0};
            numz_reg <= NUM_W'(clip_reg[2]) <<< 14;
            den_reg  <= clip_reg[3];
        end
    end

    tvt_div #(.OUT_W(XY_W)) u_div_x (
        .aclk(aclk), .en(en[LANE_STG +: DIV_STG]), .num(numx_reg), .den(den_reg),
        .q(sx), .dz(wz)
    );
    tvt_div #(.OUT_W(XY_W)) u_div_y (
        .aclk(aclk), .en(en[LANE_STG +: DIV_STG]), .num(numy_reg), .den(den_reg),
        .q(sy), .dz(dzy)
    );
    tvt_div #(.OUT_W(Z_W)) u_div_z (
        .aclk(aclk), .en(en[LANE_STG +: DIV_STG]), .num(numz_reg), .den(den_reg),
        .q(sz), .dz(dzz)
    );

    `include "triangle_vertex_transform_macros.svh"

    `TVT_ASSERT_NOW(a_dz_agree, 1'b1, (dzy === wz) && (dzz === wz))

endmodule

FILE: src/triangle_vertex_transform.sv
// Triangle vertex transform: input word is one triangle of three object-space
// vertices, output word is their screen x/y, depth and zero-w flags.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are registered; the
// user must make them only while the pipeline is empty, which the block
// itself does not enforce. An accepted word passes through 26 registers
// up to m_valid: four of matrix multiply and viewport scaling, 21 of
// divider (prep, range check, one stage per quotient bit, saturation) and the
// output register.
// Throughput is one triangle per clock while m_ready is high; each vertex has
// its own lane with its own multipliers and three pipelined dividers.
// Every stage holds its word when the next one is full and stalled, so a
// stalled receiver fills the bubbles first and s_ready drops only when all
// 26 stages hold words. Empty stages keep accepting while a result waits.
// Reset clears the stage valid bits and loads the identity matrix and a
// 640 by 480 viewport.
module triangle_vertex_transform #(
    parameter int VERTS_PER_ITEM = tvt_pkg::DEF_VERTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [tvt_pkg::ROW_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v0_x,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v0_y,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v0_z,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v1_x,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v1_y,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v1_z,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v2_x,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v2_y,
    input  logic signed [tvt_pkg::COORD_W-1:0]  s_v2_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tvt_pkg::XY_W-1:0]     m_s0_x,
    output logic signed [tvt_pkg::XY_W-1:0]     m_s0_y,
    output logic signed [tvt_pkg::Z_W-1:0]      m_s0_depth,
    output logic signed [tvt_pkg::XY_W-1:0]     m_s1_x,
    output logic signed [tvt_pkg::XY_W-1:0]     m_s1_y,
    output logic signed [tvt_pkg::Z_W-1:0]      m_s1_depth,
    output logic signed [tvt_pkg::XY_W-1:0]     m_s2_x,
    output logic signed [tvt_pkg::XY_W-1:0]     m_s2_y,
    output logic signed [tvt_pkg::Z_W-1:0]      m_s2_depth,
    output logic                                m_w_zero0,
    output logic                                m_w_zero1,
    output logic                                m_w_zero2
);
    import tvt_pkg::*;

    localparam logic signed [XY_W-1:0] XY_HI = XY_W'((1 << (XY_W - 1)) - 1);
    localparam logic signed [XY_W-1:0] XY_LO = XY_W'(1 << (XY_W - 1));

    matrix_t            mvp_reg;
    logic [SIZE_W-1:0]  width_reg, height_reg;
    logic [NSTG-1:0]    vld_reg;
    stage_en_t          en;
    logic [NSTG:0]      en_all;

    logic signed [COORD_W-1:0] in_x [0:MAX_VERTS-1];
    logic signed [COORD_W-1:0] in_y [0:MAX_VERTS-1];
    logic signed [COORD_W-1:0] in_z [0:MAX_VERTS-1];
    logic signed [XY_W-1:0]    lx [0:MAX_VERTS-1];
    logic signed [XY_W-1:0]    ly [0:MAX_VERTS-1];
    logic signed [Z_W-1:0]     lz [0:MAX_VERTS-1];
    logic                      lw [0:MAX_VERTS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvp_reg[0] <= ROW0_RST;
            mvp_reg[1] <= ROW1_RST;
            mvp_reg[2] <= ROW2_RST;
            mvp_reg[3] <= ROW3_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_ROW0:   mvp_reg[0] <= cfg_wdata;
                REG_ROW1:   mvp_reg[1] <= cfg_wdata;
                REG_ROW2:   mvp_reg[2] <= cfg_wdata;
                REG_ROW3:   mvp_reg[3] <= cfg_wdata;
                REG_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb begin
        en_all[NSTG] = m_ready;
        for (int s = NSTG - 1; s >= 0; s--) begin
            en_all[s] = !vld_reg[s] || en_all[s+1];
        end
    end
    assign en      = en_all[NSTG-1:0];
    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    assign in_x[0] = s_v0_x;  assign in_y[0] = s_v0_y;  assign in_z[0] = s_v0_z;
    assign in_x[1] = s_v1_x;  assign in_y[1] = s_v1_y;  assign in_z[1] = s_v1_z;
    assign in_x[2] = s_v2_x;  assign in_y[2] = s_v2_y;  assign in_z[2] = s_v2_z;

    for (genvar k = 0; k < MAX_VERTS; k++) begin : g_lane
        if (k < VERTS_PER_ITEM) begin : g_on
            tvt_lane u_lane (
                .aclk(aclk), .aresetn(aresetn), .en(en), .mvp(mvp_reg),
                .width(width_reg), .height(height_reg),
                .vx(in_x[k]), .vy(in_y[k]), .vz(in_z[k]),
                .sx(lx[k]), .sy(ly[k]), .sz(lz[k]), .wz(lw[k])
            );
        end else begin : g_off
            assign lx[k] = '0;
            assign ly[k] = '0;
            assign lz[k] = '0;
            assign lw[k] = 1'b0;
        end
    end

    // Merge the lanes into the output word.
    always_ff @(posedge aclk) begin
        if (en[NSTG-1]) begin
            m_s0_x <= lx[0];  m_s0_y <= ly[0];  m_s0_depth <= lz[0];
            m_s1_x <= lx[1];  m_s1_y <= ly[1];  m_s1_depth <= lz[1];
            m_s2_x <= lx[2];  m_s2_y <= ly[2];  m_s2_depth <= lz[2];
            m_w_zero0 <= lw[0];
            m_w_zero1 <= lw[1];
            m_w_zero2 <= lw[2];
        end
    end

    `include "triangle_vertex_transform_macros.svh"

    `TVT_ASSERT_NOW(a_empty_out_ready, !m_valid, s_ready)
    `TVT_ASSERT_NOW(a_wzero_sat, m_valid && m_w_zero0,
        (m_s0_x == XY_HI) || (m_s0_x == XY_LO) || (m_s0_x == '0))
    `TVT_ASSERT_NEXT(a_idle_stays, (vld_reg == '0) && !(s_valid && s_ready), !m_valid)

endmodule
